FILE: hdl/srcomp_pkg.sv
package srcomp_pkg;

  // One raw measurement
  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  // One compensated result
  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] pressure_pa;
    logic               pressure_invalid;
    logic [16:0]        humidity_q10;
  } result_t;

  // Status traveling with the divider output
  typedef struct packed {
    logic valid;
    logic zero;
  } dstat_t;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_TRIM = 3'd0,
    REG_PRESS_A   = 3'd1,
    REG_PRESS_B   = 3'd2,
    REG_PRESS_C   = 3'd3,
    REG_HUM_TRIM  = 3'd4
  } cfg_reg_e;

  // Trim formula constants
  localparam int          TEMP_OFFSET = 128000;
  localparam logic [63:0] PRESS_BIAS  = 64'h0000_8000_0000_0000;
  localparam int          PRESS_BASE  = 1048576;
  localparam int          PRESS_SCALE = 3125;
  localparam int          HUM_OFFSET  = 76800;
  localparam int          HUM_ROUND   = 16384;
  localparam int          HUM_BIAS    = 32768;
  localparam int          HUM_BASE    = 2097152;
  localparam int          HUM_HALF    = 8192;
  localparam int          HUM_MAX     = 419430400;

  localparam logic signed [63:0] PA_MIN = -64'sd2147483648;
  localparam logic signed [63:0] PA_MAX = 64'sd2147483647;

  // Divider geometry
  localparam int DIV_BITS = 64;
  localparam int DVSR_W   = 31;

  // Pipeline depths
  localparam int TEMP_STAGES  = 4;
  localparam int PCOEF_STAGES = 6;
  localparam int DIV_STAGES   = DIV_BITS + 2;
  localparam int PPOST_STAGES = 7;
  localparam int HUM_STAGES   = 11;
  localparam int HUM_ALIGN    = PCOEF_STAGES + DIV_STAGES + PPOST_STAGES - HUM_STAGES;
  localparam int TOTAL_LAT    = TEMP_STAGES + PCOEF_STAGES + DIV_STAGES + PPOST_STAGES;

endpackage

FILE: hdl/srcomp_temp.sv
module srcomp_temp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  srcomp_pkg::sample_t in_meas,
  input  logic [47:0]        temp_trim,
  output logic               out_valid,
  output logic signed [31:0] fine_temp,
  output logic [19:0]        raw_pressure,
  output logic [15:0]        raw_humidity
);
  import srcomp_pkg::*;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [TEMP_STAGES-1:0] vld;
  logic [19:0] rp [TEMP_STAGES];
  logic [15:0] rh [TEMP_STAGES];
  logic signed [31:0] x1, m2, dsq2, v1_3, q3, tf4;
  logic signed [16:0] d1;

  assign t1 = temp_trim[15:0];
  assign t2 = $signed(temp_trim[31:16]);
  assign t3 = $signed(temp_trim[47:32]);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TEMP_STAGES-2:0], in_valid};
    end
  end

  // Raw pressure / humidity ride along
  always_ff @(posedge clk) begin
    rp[0] <= in_meas.raw_pressure;
    rh[0] <= in_meas.raw_humidity;
    for (int k = 1; k < TEMP_STAGES; k++) begin
      rp[k] <= rp[k-1];
      rh[k] <= rh[k-1];
    end
  end

  // Stage 1: offsets
  always_ff @(posedge clk) begin
    x1 <= $signed(32'(in_meas.raw_temperature >> 3) - {15'd0, t1, 1'b0});
    d1 <= $signed({1'b0, in_meas.raw_temperature[19:4]}) - $signed({1'b0, t1});
  end

  // Stage 2: first products
  always_ff @(posedge clk) begin
    m2   <= x1 * 32'(t2);
    dsq2 <= 32'(d1) * 32'(d1);
  end

  // Stage 3: scale, second product
  always_ff @(posedge clk) begin
    v1_3 <= m2 >>> 11;
    q3   <= (dsq2 >>> 12) * 32'(t3);
  end

  // Stage 4: sum
  always_ff @(posedge clk) begin
    tf4 <= v1_3 + (q3 >>> 14);
  end

  assign out_valid    = vld[TEMP_STAGES-1];
  assign fine_temp    = tf4;
  assign raw_pressure = rp[TEMP_STAGES-1];
  assign raw_humidity = rh[TEMP_STAGES-1];

endmodule

FILE: hdl/srcomp_pcoef.sv
module srcomp_pcoef (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [31:0]                  fine_temp,
  input  logic [19:0]                         raw_pressure,
  input  logic [63:0]                         press_trim_a,
  input  logic [63:0]                         press_trim_b,
  output logic                                out_valid,
  output logic signed [63:0]                  dividend,
  output logic signed [srcomp_pkg::DVSR_W-1:0] divisor
);
  import srcomp_pkg::*;

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  logic [PCOEF_STAGES-1:0] vld;
  logic [19:0] rp [4];

  logic signed [33:0] a1;
  logic signed [67:0] aa_full;
  logic signed [49:0] ap5_full, ap2_full;
  logic signed [63:0] aa2, ap5_2, ap2_2, ap5_3, ap2_3, b1_3, t3_3, b4, a4;
  logic signed [79:0] b1_full, t3_full;
  logic [20:0]        pr;
  logic [63:0]        s5, n5;
  logic [79:0]        m_full;
  logic [75:0]        dv_full;

  assign p1 = press_trim_a[15:0];
  assign p2 = $signed(press_trim_a[31:16]);
  assign p3 = $signed(press_trim_a[47:32]);
  assign p4 = $signed(press_trim_a[63:48]);
  assign p5 = $signed(press_trim_b[15:0]);
  assign p6 = $signed(press_trim_b[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PCOEF_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rp[0] <= raw_pressure;
    for (int k = 1; k < 4; k++) begin
      rp[k] <= rp[k-1];
    end
  end

  // Stage 1: temperature offset
  always_ff @(posedge clk) begin
    a1 <= 34'(fine_temp) - 34'(TEMP_OFFSET);
  end

  // Stage 2: square and linear terms
  assign aa_full  = 68'(a1) * 68'(a1);
  assign ap5_full = 50'(a1) * 50'(p5);
  assign ap2_full = 50'(a1) * 50'(p2);
  always_ff @(posedge clk) begin
    aa2   <= aa_full[63:0];
    ap5_2 <= 64'(ap5_full);
    ap2_2 <= 64'(ap2_full);
  end

  // Stage 3: quadratic coefficients
  assign b1_full = 80'(aa2) * 80'(p6);
  assign t3_full = 80'(aa2) * 80'(p3);
  always_ff @(posedge clk) begin
    b1_3  <= b1_full[63:0];
    t3_3  <= t3_full[63:0];
    ap5_3 <= ap5_2;
    ap2_3 <= ap2_2;
  end

  // Stage 4: offset and sensitivity sums
  always_ff @(posedge clk) begin
    b4 <= b1_3 + (ap5_3 <<< 17) + (64'(p4) <<< 35);
    a4 <= (t3_3 >>> 8) + (ap2_3 <<< 12);
  end

  // Stage 5: bias and raw term
  assign pr = 21'(PRESS_BASE) - {1'b0, rp[3]};
  always_ff @(posedge clk) begin
    s5 <= PRESS_BIAS + a4;
    n5 <= {12'd0, pr, 31'd0} - b4;
  end

  // Stage 6: divisor and dividend
  assign m_full  = 80'(s5) * 80'(p1);
  assign dv_full = 76'(n5) * 76'(PRESS_SCALE);
  always_ff @(posedge clk) begin
    divisor  <= $signed(m_full[63:64-DVSR_W]);
    dividend <= $signed(dv_full[63:0]);
  end

  assign out_valid = vld[PCOEF_STAGES-1];

endmodule

FILE: hdl/srcomp_div.sv
module srcomp_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [srcomp_pkg::DIV_BITS-1:0] dividend,
  input  logic signed [srcomp_pkg::DVSR_W-1:0]  divisor,
  output srcomp_pkg::dstat_t                   out_stat,
  output logic [srcomp_pkg::DIV_BITS-1:0]       quotient
);
  import srcomp_pkg::*;

  // Per-step registers; index 0 holds the magnitudes
  logic [DIV_BITS-1:0] qr [DIV_BITS+1];
  logic [DVSR_W-1:0]   rm [DIV_BITS+1];
  logic [DVSR_W-1:0]   dv [DIV_BITS+1];
  logic                ng [DIV_BITS+1];
  logic                zr [DIV_BITS+1];
  logic [DIV_BITS:0]   vl;

  logic [DVSR_W:0] trial [DIV_BITS];
  logic [DVSR_W:0] diff  [DIV_BITS];
  logic            ge    [DIV_BITS];

  logic                sv_valid;
  logic                sv_zero;
  logic [DIV_BITS-1:0] q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl       <= '0;
      sv_valid <= 1'b0;
    end else begin
      vl       <= {vl[DIV_BITS-1:0], in_valid};
      sv_valid <= vl[DIV_BITS];
    end
  end

  // Sign handling
  always_ff @(posedge clk) begin
    qr[0] <= dividend[DIV_BITS-1] ? DIV_BITS'(-dividend) : dividend;
    dv[0] <= divisor[DVSR_W-1] ? DVSR_W'(-divisor) : divisor;
    rm[0] <= '0;
    ng[0] <= dividend[DIV_BITS-1] ^ divisor[DVSR_W-1];
    zr[0] <= (divisor == '0);
  end

  // Restoring steps, one quotient bit each
  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      trial[k] = {rm[k], qr[k][DIV_BITS-1]};
      diff[k]  = trial[k] - {1'b0, dv[k]};
      ge[k]    = trial[k] >= {1'b0, dv[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_BITS; k++) begin
      rm[k+1] <= ge[k] ? diff[k][DVSR_W-1:0] : trial[k][DVSR_W-1:0];
      qr[k+1] <= {qr[k][DIV_BITS-2:0], ge[k]};
      dv[k+1] <= dv[k];
      ng[k+1] <= ng[k];
      zr[k+1] <= zr[k];
    end
  end

  // Restore sign
  always_ff @(posedge clk) begin
    q_out   <= ng[DIV_BITS] ? (~qr[DIV_BITS] + DIV_BITS'(1)) : qr[DIV_BITS];
    sv_zero <= zr[DIV_BITS];
  end

  assign out_stat.valid = sv_valid;
  assign out_stat.zero  = sv_zero;
  assign quotient       = q_out;

endmodule

FILE: hdl/srcomp_ppost.sv
module srcomp_ppost (
  input  logic                clk,
  input  logic                rst,
  input  srcomp_pkg::dstat_t  in_stat,
  input  logic [63:0]         quotient,
  input  logic [63:0]         press_trim_b,
  input  logic [15:0]         press_trim_c,
  output logic                out_valid,
  output logic signed [31:0]  pressure_pa,
  output logic                pressure_invalid
);
  import srcomp_pkg::*;

  logic signed [15:0] p7, p8, p9;
  logic [PPOST_STAGES-1:0] vld;
  logic [PPOST_STAGES-2:0] bad;

  logic signed [63:0] pr1, s1, pr2, p8p2, pr3, p8p3, ss3, pr4, p8p4, t4, sum5, r6;
  logic [63:0]        ll2;
  logic [31:0]        hl2;
  logic signed [79:0] p8p_full, t_full;
  logic signed [31:0] pa7;
  logic               inv7;

  assign p7 = $signed(press_trim_b[47:32]);
  assign p8 = $signed(press_trim_b[63:48]);
  assign p9 = $signed(press_trim_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PPOST_STAGES-2:0], in_stat.valid};
    end
  end

  always_ff @(posedge clk) begin
    bad <= {bad[PPOST_STAGES-3:0], in_stat.zero};
  end

  // Stage 1: scaled copy
  always_ff @(posedge clk) begin
    pr1 <= $signed(quotient);
    s1  <= $signed(quotient) >>> 13;
  end

  // Stage 2: square split in 32-bit halves, p8 term
  assign p8p_full = 80'(pr1) * 80'(p8);
  always_ff @(posedge clk) begin
    ll2  <= 64'(s1[31:0]) * 64'(s1[31:0]);
    hl2  <= s1[63:32] * s1[31:0];
    p8p2 <= p8p_full[63:0];
    pr2  <= pr1;
  end

  // Stage 3: recombine square
  always_ff @(posedge clk) begin
    ss3  <= $signed(ll2 + {hl2[30:0], 33'd0});
    p8p3 <= p8p2;
    pr3  <= pr2;
  end

  // Stage 4: p9 term
  assign t_full = 80'(ss3) * 80'(p9);
  always_ff @(posedge clk) begin
    t4   <= t_full[63:0];
    p8p4 <= p8p3;
    pr4  <= pr3;
  end

  // Stage 5: corrections
  always_ff @(posedge clk) begin
    sum5 <= pr4 + (t4 >>> 25) + (p8p4 >>> 19);
  end

  // Stage 6: offset and final scale
  always_ff @(posedge clk) begin
    r6 <= ((sum5 >>> 8) + (64'(p7) <<< 4)) >>> 8;
  end

  // Stage 7: saturate, force zero on bad divisor
  always_ff @(posedge clk) begin
    inv7 <= bad[PPOST_STAGES-2];
    if (bad[PPOST_STAGES-2]) begin
      pa7 <= '0;
    end else if (r6 < PA_MIN) begin
      pa7 <= PA_MIN[31:0];
    end else if (r6 > PA_MAX) begin
      pa7 <= PA_MAX[31:0];
    end else begin
      pa7 <= r6[31:0];
    end
  end

  assign out_valid        = vld[PPOST_STAGES-1];
  assign pressure_pa      = pa7;
  assign pressure_invalid = inv7;

endmodule

FILE: hdl/srcomp_hum.sv
module srcomp_hum (
  input  logic               clk,
  input  logic signed [31:0] fine_temp,
  input  logic [15:0]        raw_humidity,
  input  logic [63:0]        hum_trim,
  output logic signed [31:0] fine_temp_out,
  output logic [16:0]        humidity_q10
);
  import srcomp_pkg::*;

  localparam int TF_DEPTH = HUM_STAGES + HUM_ALIGN;

  logic [7:0]         h1, h3;
  logic signed [15:0] h2;
  logic [11:0]        h4;
  logic signed [11:0] h5;
  logic signed [7:0]  h6;

  logic signed [31:0] tfp [TF_DEPTH];
  logic [16:0]        hmd [HUM_ALIGN];

  logic [15:0]        rh1;
  logic signed [31:0] v1, hv2, m6_2, m3_2, base2;
  logic signed [31:0] a3, x6_3, y3_3, a4, b4, a5, b5, a6, b6, a7, b7;
  logic signed [31:0] v8, s8, sq9, v9, w10, v10, vf;
  logic [16:0]        hum11;

  assign h1 = hum_trim[7:0];
  assign h2 = $signed(hum_trim[23:8]);
  assign h3 = hum_trim[31:24];
  assign h4 = hum_trim[43:32];
  assign h5 = $signed(hum_trim[55:44]);
  assign h6 = $signed(hum_trim[63:56]);

  // Fine temperature delayed to the pressure latency
  always_ff @(posedge clk) begin
    tfp[0] <= fine_temp;
    for (int k = 1; k < TF_DEPTH; k++) begin
      tfp[k] <= tfp[k-1];
    end
  end

  // Stage 1: temperature offset
  always_ff @(posedge clk) begin
    v1  <= fine_temp - 32'(HUM_OFFSET);
    rh1 <= raw_humidity;
  end

  // Stage 2: products with temperature
  always_ff @(posedge clk) begin
    hv2   <= v1 * 32'(h5);
    m6_2  <= v1 * 32'(h6);
    m3_2  <= v1 * $signed({24'd0, h3});
    base2 <= $signed(32'({rh1, 14'd0}) - {h4, 20'd0});
  end

  // Stage 3
  always_ff @(posedge clk) begin
    a3   <= (base2 - hv2 + 32'(HUM_ROUND)) >>> 15;
    x6_3 <= m6_2 >>> 10;
    y3_3 <= (m3_2 >>> 11) + 32'(HUM_BIAS);
  end

  // Stage 4
  always_ff @(posedge clk) begin
    b4 <= x6_3 * y3_3;
    a4 <= a3;
  end

  // Stage 5
  always_ff @(posedge clk) begin
    b5 <= (b4 >>> 10) + 32'(HUM_BASE);
    a5 <= a4;
  end

  // Stage 6
  always_ff @(posedge clk) begin
    b6 <= b5 * 32'(h2);
    a6 <= a5;
  end

  // Stage 7
  always_ff @(posedge clk) begin
    b7 <= (b6 + 32'(HUM_HALF)) >>> 14;
    a7 <= a6;
  end

  // Stage 8
  always_ff @(posedge clk) begin
    v8 <= a7 * b7;
  end

  // Stage 9: square of scaled value
  assign s8 = v8 >>> 15;
  always_ff @(posedge clk) begin
    sq9 <= s8 * s8;
    v9  <= v8;
  end

  // Stage 10
  always_ff @(posedge clk) begin
    w10 <= (sq9 >>> 7) * $signed({24'd0, h1});
    v10 <= v9;
  end

  // Stage 11: clamp to 0..100 %RH
  assign vf = v10 - (w10 >>> 4);
  always_ff @(posedge clk) begin
    if (vf[31]) begin
      hum11 <= '0;
    end else if (vf > 32'(HUM_MAX)) begin
      hum11 <= 17'(HUM_MAX >> 12);
    end else begin
      hum11 <= vf[28:12];
    end
  end

  // Align with the pressure path
  always_ff @(posedge clk) begin
    hmd[0] <= hum11;
    for (int k = 1; k < HUM_ALIGN; k++) begin
      hmd[k] <= hmd[k-1];
    end
  end

  assign fine_temp_out = tfp[TF_DEPTH-1];
  assign humidity_q10  = hmd[HUM_ALIGN-1];

endmodule

FILE: hdl/sensor_raw_compensation.sv
// Channel   Ports                                 Transaction
// --------  ------------------------------------  --------------------------------
// measure   start, busy, meas                     start high and busy low at edge
// result    done, result                          done high for one cycle
// config    cfg_valid, cfg_ready, cfg_index,      cfg_valid and cfg_ready high
//           cfg_data
//
// One measurement per cycle.
// The latency is set by the 64-step restoring divider of the pressure path.
// rst is synchronous; busy is high only during reset, cfg_ready is always high.
// The pipeline never stalls: the receiver must take done when it comes.
module sensor_raw_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  srcomp_pkg::sample_t                 meas,
  output logic                                done,
  output srcomp_pkg::result_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srcomp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                         cfg_data
);
  import srcomp_pkg::*;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_a;
  logic [63:0] press_trim_b;
  logic [15:0] press_trim_c;
  logic [63:0] hum_trim;

  logic               t_valid;
  logic signed [31:0] t_fine;
  logic [19:0]        t_rp;
  logic [15:0]        t_rh;

  logic                      c_valid;
  logic signed [63:0]        c_dividend;
  logic signed [DVSR_W-1:0]  c_divisor;

  dstat_t              d_stat;
  logic [DIV_BITS-1:0] d_quo;

  logic               p_valid;
  logic signed [31:0] p_pa;
  logic               p_inv;

  logic signed [31:0] h_fine;
  logic [16:0]        h_hum;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Trim registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim    <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
      hum_trim     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_TRIM: temp_trim    <= cfg_data[47:0];
        REG_PRESS_A:   press_trim_a <= cfg_data;
        REG_PRESS_B:   press_trim_b <= cfg_data;
        REG_PRESS_C:   press_trim_c <= cfg_data[15:0];
        REG_HUM_TRIM:  hum_trim     <= cfg_data;
        default: ;
      endcase
    end
  end

  srcomp_temp u_temp (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .in_meas      (meas),
    .temp_trim    (temp_trim),
    .out_valid    (t_valid),
    .fine_temp    (t_fine),
    .raw_pressure (t_rp),
    .raw_humidity (t_rh)
  );

  srcomp_pcoef u_pcoef (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (t_valid),
    .fine_temp    (t_fine),
    .raw_pressure (t_rp),
    .press_trim_a (press_trim_a),
    .press_trim_b (press_trim_b),
    .out_valid    (c_valid),
    .dividend     (c_dividend),
    .divisor      (c_divisor)
  );

  srcomp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .dividend (c_dividend),
    .divisor  (c_divisor),
    .out_stat (d_stat),
    .quotient (d_quo)
  );

  srcomp_ppost u_ppost (
    .clk              (clk),
    .rst              (rst),
    .in_stat          (d_stat),
    .quotient         (d_quo),
    .press_trim_b     (press_trim_b),
    .press_trim_c     (press_trim_c),
    .out_valid        (p_valid),
    .pressure_pa      (p_pa),
    .pressure_invalid (p_inv)
  );

  srcomp_hum u_hum (
    .clk           (clk),
    .fine_temp     (t_fine),
    .raw_humidity  (t_rh),
    .hum_trim      (hum_trim),
    .fine_temp_out (h_fine),
    .humidity_q10  (h_hum)
  );

  // Result assembly
  assign done = p_valid;
  always_comb begin
    result.fine_temperature = h_fine;
    result.pressure_pa      = p_pa;
    result.pressure_invalid = p_inv;
    result.humidity_q10     = h_hum;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching start");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.pressure_invalid) |-> (result.pressure_pa == 32'sd0))
    else $error("invalid pressure not forced to zero");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.humidity_q10 <= 17'(HUM_MAX >> 12)))
    else $error("humidity out of range");
`endif

endmodule

FILE: test/srcomp_checker.sv
`timescale 1ns / 1ps

// Watches the measure, result and config channels of the compensation block,
// predicts each result from its own copy of the trim registers and compares.
module srcomp_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  srcomp_pkg::sample_t              meas,
  input  logic                             done,
  input  srcomp_pkg::result_t              result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [srcomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data,
  output int                               errors,
  output int                               pending
);
  import srcomp_pkg::*;

  // Shadow copy of the trim registers
  logic [47:0] temp_trim;
  logic [63:0] press_trim_a, press_trim_b, hum_trim;
  logic [15:0] press_trim_c;

  result_t expected_results[$];

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  // Compensation of one raw sample with the current trim words
  function automatic result_t compensate(sample_t s);
    logic [31:0] t1, t2, t3, raw, d, v1, v2, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, ma, mb, num;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, ha, hb, hs;
    result_t r;
    // fine temperature, 32-bit wrapping
    t1 = {16'd0, temp_trim[15:0]};
    t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
    t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
    raw = {12'd0, s.raw_temperature};
    v1 = asr32(((raw >> 3) - (t1 << 1)) * t2, 11);
    d = (raw >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.fine_temperature = tf;

    // pressure, 64-bit wrapping
    p1 = {48'd0, press_trim_a[15:0]};
    p2 = {{48{press_trim_a[31]}}, press_trim_a[31:16]};
    p3 = {{48{press_trim_a[47]}}, press_trim_a[47:32]};
    p4 = {{48{press_trim_a[63]}}, press_trim_a[63:48]};
    p5 = {{48{press_trim_b[15]}}, press_trim_b[15:0]};
    p6 = {{48{press_trim_b[31]}}, press_trim_b[31:16]};
    p7 = {{48{press_trim_b[47]}}, press_trim_b[47:32]};
    p8 = {{48{press_trim_b[63]}}, press_trim_b[63:48]};
    p9 = {{48{press_trim_c[15]}}, press_trim_c};
    a = {{32{tf[31]}}, tf} - 64'(TEMP_OFFSET);
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr64(a * a * p3, 8) + ((a * p2) << 12);
    a = asr64((PRESS_BIAS + a) * p1, 33);
    if (a == 64'd0) begin
      r.pressure_pa = '0;
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'(PRESS_BASE) - {44'd0, s.raw_pressure};
      num = ((p << 31) - b) * 64'(PRESS_SCALE);
      // truncating signed divide on magnitudes; most negative / -1 wraps
      ma = num[63] ? 64'd0 - num : num;
      mb = a[63] ? 64'd0 - a : a;
      q = ma / mb;
      p = (num[63] != a[63]) ? 64'd0 - q : q;
      q = asr64(p, 13);
      a = asr64(p9 * q * q, 25);
      b = asr64(p8 * p, 19);
      p = asr64(asr64(p + a + b, 8) + (p7 << 4), 8);
      if ($signed(p) < PA_MIN) p = PA_MIN;
      else if ($signed(p) > PA_MAX) p = PA_MAX;
      r.pressure_pa = p[31:0];
      r.pressure_invalid = 1'b0;
    end

    // humidity, 32-bit wrapping then clamp
    h1 = {24'd0, hum_trim[7:0]};
    h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
    h3 = {24'd0, hum_trim[31:24]};
    h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
    h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
    h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};
    raw = {16'd0, s.raw_humidity};
    v = tf - 32'(HUM_OFFSET);
    ha = asr32((raw << 14) - (h4 << 20) - (h5 * v) + 32'(HUM_ROUND), 15);
    hb = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'(HUM_BIAS));
    hb = asr32(hb, 10) + 32'(HUM_BASE);
    hb = asr32(hb * h2 + 32'(HUM_HALF), 14);
    v = ha * hb;
    hs = asr32(v, 15);
    v = v - asr32(asr32(hs * hs, 7) * h1, 4);
    if (v[31]) v = '0;
    else if (v > 32'(HUM_MAX)) v = 32'(HUM_MAX);
    r.humidity_q10 = v[28:12];
    return r;
  endfunction

  // Track register writes, predict on each accepted measurement, check results
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      temp_trim <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
      hum_trim <= '0;
      expected_results.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_TEMP_TRIM: temp_trim <= cfg_data[47:0];
          REG_PRESS_A:   press_trim_a <= cfg_data;
          REG_PRESS_B:   press_trim_b <= cfg_data;
          REG_PRESS_C:   press_trim_c <= cfg_data[15:0];
          REG_HUM_TRIM:  hum_trim <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_results.push_back(compensate(meas));
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected: %p", $time, result);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.fine_temperature !== result.fine_temperature ||
              exp_r.pressure_pa !== result.pressure_pa ||
              exp_r.pressure_invalid !== result.pressure_invalid ||
              exp_r.humidity_q10 !== result.humidity_q10) begin
            $display("%0t: mismatch expected t=%0d p=%0d inv=%0d h=%0d", $time,
                     exp_r.fine_temperature, exp_r.pressure_pa,
                     exp_r.pressure_invalid, exp_r.humidity_q10);
            $display("%0t:          actual   t=%0d p=%0d inv=%0d h=%0d", $time,
                     result.fine_temperature, result.pressure_pa,
                     result.pressure_invalid, result.humidity_q10);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule

FILE: test/tb_sensor_raw_compensation.sv
`timescale 1ns / 1ps

module tb_sensor_raw_compensation;
  import srcomp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 3'd7;
  localparam int RANDOM_PER_SETTING = 190;
  localparam int SETTINGS_RUN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, cfg_ready;
  sample_t meas = '0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int errors, pending;
  int samples_sent = 0;
  int cfg_writes = 0;
  bit no_gaps;

  // Typical factory trim words
  localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TYP_PB = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
  localparam logic [15:0] TYP_PC = 16'd6000;
  localparam logic [63:0] TYP_HUM = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_raw_compensation dut (.*);

  srcomp_checker checker_i (.*);

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_writes++;
  endtask

  // Reprogram every trim word; only once all results are back
  task automatic load_trims(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [63:0] pc, logic [63:0] h);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_TEMP_TRIM, t);
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_C, pc);
    write_reg(REG_HUM_TRIM, h);
    write_reg(SPARE_IDX, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    bit ok;
    int gap;
    meas <= '{raw_temperature: rt, raw_pressure: rp, raw_humidity: rh};
    start <= 1'b1;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    samples_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [19:0] pick20();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 20'd400000 + 20'($urandom_range(0, 250000));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic random_samples(int n);
    repeat (n) send_sample(pick20(), pick20(),
                           ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Typical trims: field extremes and typical readings
    load_trims(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, TYP_HUM);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample('0, '1, '0);
    send_sample('1, '0, '1);
    send_sample(20'd519888, 20'd415148, 16'd31000);
    send_sample(20'd480000, 20'd330000, 16'd20000);
    send_sample(20'd600000, 20'd500000, 16'd45000);
    send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_sample(20'h55555, 20'hAAAAA, 16'h5555);
    random_samples(RANDOM_PER_SETTING);

    // Zero pressure divisor: p1 cleared
    load_trims(TYP_TEMP, {TYP_PA[63:16], 16'd0}, TYP_PB, TYP_PC, TYP_HUM);
    send_sample(20'd519888, 20'd415148, 16'd31000);
    send_sample('1, '1, '1);
    random_samples(RANDOM_PER_SETTING / 2);

    // All-zero and all-ones trims
    load_trims('0, '0, '0, '0, '0);
    send_sample('1, '1, '1);
    random_samples(RANDOM_PER_SETTING / 2);
    load_trims('1, '1, '1, '1, '1);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    random_samples(RANDOM_PER_SETTING);

    // Most negative / most positive coefficients
    load_trims({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
               {4{16'h8000}}, 64'h8000, 64'h80_800_800_FF_8000_FF);
    random_samples(RANDOM_PER_SETTING / 2);
    load_trims({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
               {4{16'h7FFF}}, 64'h7FFF, 64'h7F_7FF_7FF_00_7FFF_00);
    random_samples(RANDOM_PER_SETTING / 2);

    // Random trims, some fully random, some near typical
    for (int k = 0; k < SETTINGS_RUN; k++) begin
      if (k % 2 == 0)
        load_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      else
        load_trims(TYP_TEMP ^ 48'($urandom_range(0, 255)),
                   TYP_PA ^ 64'($urandom_range(0, 255)),
                   TYP_PB ^ {8'($urandom), 56'd0}, {$urandom, $urandom},
                   TYP_HUM ^ {$urandom, 32'd0});
      random_samples(RANDOM_PER_SETTING - 75);
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
    $display("Compensated %0d samples over %0d register writes,", samples_sent, cfg_writes);
    $display("including zero divisor, extreme and random trim words.");
    if (errors == 0) begin
      $display("tb_sensor_raw_compensation: done, clean");
    end else begin
      $display("tb_sensor_raw_compensation: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_sensor_raw_compensation: done, errors");
    $finish;
  end
endmodule
